// File: src/frle_pkg.sv
package frle_pkg;

   localparam int MAX_FRAME_LEN = 1048576;
   localparam int POS_W = (MAX_FRAME_LEN > 1) ? $clog2(MAX_FRAME_LEN) : 1;

   localparam int CELL_W = 8;
   localparam int LEN_W = 21;
   localparam int LIMIT_W = 32;
   localparam int BYTES_W = 32;
   localparam int FRAMES_W = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_LEN = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTE_LIMIT = 1'b1;

   localparam logic [CELL_W-1:0] RUN_MAX = 8'd255;
   localparam logic [BYTES_W-1:0] PAIR_BYTES = 32'd2;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

   typedef struct packed {
      logic [CELL_W-1:0]   run_count;
      logic [CELL_W-1:0]   run_value;
      logic                end_of_frame;
      logic                frame_rejected;
      logic [FRAMES_W-1:0] rounds_saved;
      logic                last;
   } result_type;

endpackage

// File: src/frle_req_if.sv
interface frle_req_if
   import frle_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [CELL_W-1:0] cell_value;

   modport source (output valid, output cell_value, input ready);
   modport sink (input valid, input cell_value, output ready);
endinterface

interface frle_rsp_if
   import frle_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [CELL_W-1:0]   run_count;
   logic [CELL_W-1:0]   run_value;
   logic                end_of_frame;
   logic                frame_rejected;
   logic [FRAMES_W-1:0] rounds_saved;
   logic                last;

   modport source (output valid, output run_count, output run_value, output end_of_frame,
                   output frame_rejected, output rounds_saved, output last, input ready);
   modport sink (input valid, input run_count, input run_value, input end_of_frame,
                 input frame_rejected, input rounds_saved, input last, output ready);
endinterface

// File: src/frame_run_length_encoder_top.sv
// Frame run-length encoder.
// req_chan carries one cell byte per word; cells are grouped into frames of
// frame_len cells (csr index 0, 0 acts as 1, clamped to MAX_FRAME_LEN).
// rsp_chan carries (run_count, run_value) pairs plus end_of_frame, the
// rejection flag, the running frame count and a last flag per input cell.
// A cell yields zero, one or two words; a cell that closes a frame flushes
// the open run. Frames that start with the byte total at or above
// byte_limit (csr index 1) are dropped and report one rejection word.
// Configuration is written through csr_wr_en / csr_index / csr_wdata.
// Throughput: one cell per cycle while req_chan.ready is high; a cell that
// yields two words fills two queue entries. Words are registered in the
// queue and shown on rsp_chan from its head. The cell is decoded in the
// accept cycle and its words land in a four-entry result queue;
// req_chan.ready is high while the queue has room for two words.
// When the receiver stalls, the queue fills and req_chan.ready drops; the
// word at the head of the queue holds steady until taken.
// Reset (synchronous, active high) empties the queue, restarts the frame
// and clears the byte and frame counters; control and configuration
// registers return to their defaults, but the queue payload is not reset.
module frame_run_length_encoder_top
   import frle_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   frle_req_if.sink              req_chan,
   frle_rsp_if.source            rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [LEN_W-1:0]    frame_len_ff;
   logic [LIMIT_W-1:0]  byte_limit_ff;

   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [CELL_W-1:0]   run_len_ff, run_len_in;
   logic [CELL_W-1:0]   run_byte_ff, run_byte_in;
   logic [BYTES_W-1:0]  bytes_ff, bytes_in;
   logic [FRAMES_W-1:0] frames_ff, frames_in;
   logic                drop_ff, drop_in;

   result_type                fifo_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]     rd_ptr_ff;
   logic [FIFO_PTR_W:0]       count_ff, count_in;

   logic                accept, pop;
   logic [POS_W-1:0]    last_pos;
   logic                first_cell, is_last, emit_mid;
   logic [BYTES_W-1:0]  bytes_mid;
   result_type          mid_res, final_res;
   logic [FIFO_PTR_W-1:0] wr_ptr, wr_ptr2;
   logic [FIFO_PTR_W:0]   push_n;

   function automatic logic [BYTES_W-1:0] sat_add2(input logic [BYTES_W-1:0] v);
      if (v > ({BYTES_W{1'b1}} - PAIR_BYTES)) begin
         return {BYTES_W{1'b1}};
      end
      return v + PAIR_BYTES;
   endfunction

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_len_ff  <= LEN_W'(1);
         byte_limit_ff <= {LIMIT_W{1'b1}};
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FRAME_LEN:  frame_len_ff  <= csr_wdata[LEN_W-1:0];
            CSR_BYTE_LIMIT: byte_limit_ff <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // last cell position of the effective frame length
   always_comb begin
      if (frame_len_ff == '0) begin
         last_pos = '0;
      end else if (32'(frame_len_ff) > 32'(MAX_FRAME_LEN)) begin
         last_pos = POS_W'(MAX_FRAME_LEN - 1);
      end else begin
         last_pos = POS_W'(frame_len_ff - LEN_W'(1));
      end
   end

   assign accept = req_chan.valid && req_chan.ready;
   assign pop    = rsp_chan.valid && rsp_chan.ready;

   always_comb begin
      first_cell = (pos_ff == '0);
      is_last    = (pos_ff >= last_pos);
      drop_in    = first_cell ? (bytes_ff >= byte_limit_ff) : drop_ff;
      emit_mid   = !first_cell && !drop_ff &&
                   ((run_len_ff >= RUN_MAX) || (req_chan.cell_value != run_byte_ff));

      run_len_in  = run_len_ff;
      run_byte_in = run_byte_ff;
      if ((first_cell && !drop_in) || emit_mid) begin
         run_len_in  = CELL_W'(1);
         run_byte_in = req_chan.cell_value;
      end else if (!first_cell && !drop_ff) begin
         run_len_in = run_len_ff + CELL_W'(1);
      end

      bytes_mid = emit_mid ? sat_add2(bytes_ff) : bytes_ff;
      bytes_in  = bytes_mid;
      frames_in = frames_ff;
      if (is_last && !drop_in) begin
         bytes_in  = sat_add2(bytes_mid);
         frames_in = frames_ff + FRAMES_W'(1);
      end

      pos_in = is_last ? '0 : pos_ff + POS_W'(1);

      mid_res.run_count      = run_len_ff;
      mid_res.run_value      = run_byte_ff;
      mid_res.end_of_frame   = 1'b0;
      mid_res.frame_rejected = 1'b0;
      mid_res.rounds_saved   = frames_ff;
      mid_res.last           = !is_last;

      final_res.run_count      = drop_in ? '0 : run_len_in;
      final_res.run_value      = drop_in ? '0 : run_byte_in;
      final_res.end_of_frame   = 1'b1;
      final_res.frame_rejected = drop_in;
      final_res.rounds_saved   = frames_in;
      final_res.last           = 1'b1;
   end

   assign wr_ptr  = rd_ptr_ff + count_ff[FIFO_PTR_W-1:0];
   assign wr_ptr2 = wr_ptr + FIFO_PTR_W'(emit_mid);
   assign push_n  = accept ? ((FIFO_PTR_W+1)'(emit_mid) + (FIFO_PTR_W+1)'(is_last)) : '0;
   assign count_in = count_ff + push_n - (FIFO_PTR_W+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         run_len_ff  <= '0;
         run_byte_ff <= '0;
         bytes_ff    <= '0;
         frames_ff   <= '0;
         drop_ff     <= 1'b0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         if (accept) begin
            pos_ff      <= pos_in;
            run_len_ff  <= run_len_in;
            run_byte_ff <= run_byte_in;
            bytes_ff    <= bytes_in;
            frames_ff   <= frames_in;
            drop_ff     <= drop_in;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   // result queue payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept && emit_mid) begin
         fifo_ff[wr_ptr] <= mid_res;
      end
      if (accept && is_last) begin
         fifo_ff[wr_ptr2] <= final_res;
      end
   end

   // leave room for the two words a frame-closing cell may produce
   assign req_chan.ready = (count_ff <= (FIFO_PTR_W+1)'(FIFO_DEPTH - 2));

   assign rsp_chan.valid          = (count_ff != '0);
   assign rsp_chan.run_count      = fifo_ff[rd_ptr_ff].run_count;
   assign rsp_chan.run_value      = fifo_ff[rd_ptr_ff].run_value;
   assign rsp_chan.end_of_frame   = fifo_ff[rd_ptr_ff].end_of_frame;
   assign rsp_chan.frame_rejected = fifo_ff[rd_ptr_ff].frame_rejected;
   assign rsp_chan.rounds_saved   = fifo_ff[rd_ptr_ff].rounds_saved;
   assign rsp_chan.last           = fifo_ff[rd_ptr_ff].last;

endmodule

// File: src/frle_checker.sv
module frle_checker
   import frle_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   frle_req_if.sink   req_chan,
   frle_rsp_if.source rsp_chan
);

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=>
         rsp_chan.valid && $stable(rsp_chan.run_count) && $stable(rsp_chan.run_value)
         && $stable(rsp_chan.rounds_saved) && $stable(rsp_chan.last))
      else $error("rsp word changed while stalled");

   // queue is empty and open for cells right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid && req_chan.ready)
      else $error("queue not empty right after reset");

   // a rejection word closes its frame and carries no pair
   a_reject_form: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.frame_rejected |->
         rsp_chan.end_of_frame && rsp_chan.last && (rsp_chan.run_count == '0))
      else $error("malformed rejection word");

   // every encoded pair has a nonzero run
   a_pair_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.frame_rejected |-> (rsp_chan.run_count != '0))
      else $error("pair with zero run length");

   // a frame end is always the last word of its cell
   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.end_of_frame |-> rsp_chan.last)
      else $error("frame end not marked last");

endmodule

bind frame_run_length_encoder_top frle_checker u_frle_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);
